// ===== src/sqv_pkg.sv =====
`default_nettype none
package sqv_pkg;

	localparam int FRAC_BITS       = 8;
	localparam int TRIG_BITS       = 14;
	localparam int CORDIC_STEPS    = 14;
	localparam int STEPS_PER_STAGE = 2;
	localparam int CORDIC_STAGES   = CORDIC_STEPS / STEPS_PER_STAGE;
	localparam int GAIN_START      = 9949;
	localparam int INSET           = (75 * (1 << FRAC_BITS) + 5000) / 10000;
	localparam int ROUND_SHIFT     = TRIG_BITS - FRAC_BITS;
	localparam logic [12:0] MAX_VERTICES = 13'd4096;
	localparam logic [20:0] TEX_MAX      = 21'h1FFFFF;
	localparam logic [1:0]  CORNER_LAST  = 2'd3;

	typedef logic signed [17:0] trig_t;
	typedef logic signed [16:0] ang_t;

	// Sprite data after the setup stage, reduced to what the corners need.
	typedef struct packed {
		logic               oor;
		logic [11:0]        base;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic [20:0]        u0;
		logic [20:0]        u1;
		logic [20:0]        v0;
		logic [20:0]        v1;
		logic [31:0]        color;
		logic signed [24:0] bx;
		logic signed [24:0] by;
		logic signed [20:0] wx;
		logic signed [20:0] hy;
	} sprite_t;

	typedef struct packed {
		sprite_t spr;
		trig_t   x;
		trig_t   y;
		ang_t    t;
		logic    neg;
	} cord_t;

	typedef struct packed {
		sprite_t spr;
		trig_t   sin_v;
		trig_t   cos_v;
	} item_t;

	function automatic ang_t atan_unit(input int i);
		ang_t r;
		case (i)
			0: r = 17'sd8192;
			1: r = 17'sd4836;
			2: r = 17'sd2555;
			3: r = 17'sd1297;
			4: r = 17'sd651;
			5: r = 17'sd326;
			6: r = 17'sd163;
			7: r = 17'sd81;
			8: r = 17'sd41;
			9: r = 17'sd20;
			10: r = 17'sd10;
			11: r = 17'sd5;
			12: r = 17'sd3;
			default: r = 17'sd1;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== src/sqv_if.sv =====
`default_nettype none
interface sqv_sprite_if;
	logic        valid;
	logic        ready;
	logic [9:0]  slot;
	logic [15:0] pos_x;
	logic [15:0] pos_y;
	logic [11:0] tex_left;
	logic [11:0] tex_top;
	logic [11:0] tex_width;
	logic [11:0] tex_height;
	logic [15:0] scale_xy;
	logic [15:0] origin_x;
	logic [15:0] origin_y;
	logic [15:0] angle;
	logic [31:0] color;

	modport source (output valid, slot, pos_x, pos_y, tex_left, tex_top, tex_width,
		tex_height, scale_xy, origin_x, origin_y, angle, color, input ready);
	modport sink (input valid, slot, pos_x, pos_y, tex_left, tex_top, tex_width,
		tex_height, scale_xy, origin_x, origin_y, angle, color, output ready);
endinterface

interface sqv_vertex_if;
	logic        valid;
	logic        ready;
	logic [11:0] vertex_address;
	logic [31:0] vertex_x;
	logic [31:0] vertex_y;
	logic [20:0] tex_u;
	logic [20:0] tex_v;
	logic [31:0] vertex_color;
	logic        out_of_range;
	logic        last;

	modport source (output valid, vertex_address, vertex_x, vertex_y, tex_u, tex_v,
		vertex_color, out_of_range, last, input ready);
	modport sink (input valid, vertex_address, vertex_x, vertex_y, tex_u, tex_v,
		vertex_color, out_of_range, last, output ready);
endinterface
`default_nettype wire

// ===== src/sqv_front.sv =====
`default_nettype none
module sqv_front
	import sqv_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        en,
	input  wire logic [12:0] cap,
	sqv_sprite_if.sink       sprite,
	output logic             item_valid,
	output item_t            item
);

	logic [CORDIC_STAGES:0] valid_s;
	cord_t                  cord_s [CORDIC_STAGES+1];
	cord_t                  setup;

	logic signed [7:0]  sx, sy;
	logic signed [16:0] nox, noy;
	logic [12:0]        usum, vsum;
	logic signed [22:0] u1w, v1w;
	logic signed [15:0] ang16;
	ang_t               t0;

	assign sprite.ready = en;

	// Setup: scales, texture rectangle, capacity check and angle folding.
	always_comb begin
		sx    = $signed(sprite.scale_xy[7:0]);
		sy    = $signed(sprite.scale_xy[15:8]);
		nox   = -$signed({sprite.origin_x[15], sprite.origin_x});
		noy   = -$signed({sprite.origin_y[15], sprite.origin_y});
		usum  = {1'b0, sprite.tex_left} + {1'b0, sprite.tex_width};
		vsum  = {1'b0, sprite.tex_top} + {1'b0, sprite.tex_height};
		u1w   = $signed({2'b00, usum, 8'h00}) - 23'(INSET);
		v1w   = $signed({2'b00, vsum, 8'h00}) - 23'(INSET);
		ang16 = $signed(sprite.angle);
		t0    = {ang16[15], ang16};
		setup = '0;
		setup.spr.oor   = ({1'b0, sprite.slot, 2'b00} >= cap);
		setup.spr.base  = {sprite.slot, 2'b00};
		setup.spr.pos_x = $signed(sprite.pos_x);
		setup.spr.pos_y = $signed(sprite.pos_y);
		setup.spr.u0    = {1'b0, sprite.tex_left, 8'h00} + 21'(INSET);
		setup.spr.v0    = {1'b0, sprite.tex_top, 8'h00} + 21'(INSET);
		setup.spr.u1    = (u1w < 0) ? 21'd0 : u1w[20:0];
		setup.spr.v1    = (v1w < 0) ? 21'd0 : v1w[20:0];
		setup.spr.color = sprite.color;
		setup.spr.bx    = nox * sx;
		setup.spr.by    = noy * sy;
		setup.spr.wx    = $signed({1'b0, sprite.tex_width}) * sx;
		setup.spr.hy    = $signed({1'b0, sprite.tex_height}) * sy;
		setup.x         = 18'(GAIN_START);
		setup.y         = '0;
		setup.neg       = 1'b0;
		setup.t         = t0;
		if (t0 > 17'sd16384) begin
			setup.t   = t0 - 17'sd32768;
			setup.neg = 1'b1;
		end else if (t0 < -17'sd16384) begin
			setup.t   = t0 + 17'sd32768;
			setup.neg = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s[0] <= 1'b0;
		end else if (en) begin
			valid_s[0] <= sprite.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cord_s[0] <= setup;
		end
	end

	// Rotation stages, two CORDIC iterations each.
	for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
		cord_t nxt;

		always_comb begin
			trig_t dx, dy;
			nxt = cord_s[g];
			for (int j = 0; j < STEPS_PER_STAGE; j++) begin
				dx = nxt.y >>> (g * STEPS_PER_STAGE + j);
				dy = nxt.x >>> (g * STEPS_PER_STAGE + j);
				if (nxt.t >= 0) begin
					nxt.x = nxt.x - dx;
					nxt.y = nxt.y + dy;
					nxt.t = nxt.t - atan_unit(g * STEPS_PER_STAGE + j);
				end else begin
					nxt.x = nxt.x + dx;
					nxt.y = nxt.y - dy;
					nxt.t = nxt.t + atan_unit(g * STEPS_PER_STAGE + j);
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[g+1] <= 1'b0;
			end else if (en) begin
				valid_s[g+1] <= valid_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				cord_s[g+1] <= nxt;
			end
		end
	end

	always_comb begin
		item_valid = valid_s[CORDIC_STAGES];
		item.spr   = cord_s[CORDIC_STAGES].spr;
		item.cos_v = cord_s[CORDIC_STAGES].neg ? -cord_s[CORDIC_STAGES].x
			: cord_s[CORDIC_STAGES].x;
		item.sin_v = cord_s[CORDIC_STAGES].neg ? -cord_s[CORDIC_STAGES].y
			: cord_s[CORDIC_STAGES].y;
	end

endmodule
`default_nettype wire

// ===== src/sqv_corner.sv =====
`default_nettype none
module sqv_corner
	import sqv_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  item_valid,
	input  item_t      item,
	output logic       take,
	sqv_vertex_if.source vertex
);

	item_t       ser_q;
	logic        ser_valid_q;
	logic [1:0]  corner_q;
	logic        en, ser_done;

	logic               a_valid_s1;
	logic               a_oor_s1, a_last_s1;
	logic [11:0]        a_addr_s1;
	logic signed [15:0] a_px_s1, a_py_s1;
	logic [20:0]        a_u_s1, a_v_s1;
	logic [31:0]        a_color_s1;
	logic signed [43:0] a_xc_s1, a_ys_s1, a_xs_s1, a_yc_s1;

	logic               right, bottom;
	logic signed [25:0] cx, cy;
	logic signed [44:0] sum_x, sum_y;
	logic signed [45:0] tot_x, tot_y;

	assign en       = !vertex.valid || vertex.ready;
	assign ser_done = ser_q.spr.oor || (corner_q == CORNER_LAST);
	assign take     = en && (!ser_valid_q || ser_done);

	always_comb begin
		right  = (corner_q == 2'd1) || (corner_q == 2'd2);
		bottom = corner_q[1];
		cx = 26'(ser_q.spr.bx) + (right ? 26'(ser_q.spr.wx) : 26'sd0);
		cy = 26'(ser_q.spr.by) + (bottom ? 26'(ser_q.spr.hy) : 26'sd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ser_valid_q  <= 1'b0;
			corner_q     <= 2'd0;
			a_valid_s1   <= 1'b0;
			vertex.valid <= 1'b0;
		end else if (en) begin
			a_valid_s1   <= ser_valid_q;
			vertex.valid <= a_valid_s1;
			if (take) begin
				ser_valid_q <= item_valid;
				corner_q    <= 2'd0;
			end else begin
				corner_q <= corner_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ser_q <= item;
		end
	end

	// Corner stage: pick the corner and form the four rotation products.
	always_ff @(posedge clk) begin
		if (en) begin
			a_oor_s1   <= ser_q.spr.oor;
			a_last_s1  <= ser_done;
			a_addr_s1  <= ser_q.spr.base + {10'd0, corner_q};
			a_px_s1    <= ser_q.spr.pos_x;
			a_py_s1    <= ser_q.spr.pos_y;
			a_u_s1     <= right ? ser_q.spr.u1 : ser_q.spr.u0;
			a_v_s1     <= bottom ? ser_q.spr.v1 : ser_q.spr.v0;
			a_color_s1 <= ser_q.spr.color;
			a_xc_s1    <= cx * ser_q.cos_v;
			a_ys_s1    <= cy * ser_q.sin_v;
			a_xs_s1    <= cx * ser_q.sin_v;
			a_yc_s1    <= cy * ser_q.cos_v;
		end
	end

	// Sum, round Q14 to the output fraction, translate and saturate.
	always_comb begin
		sum_x = 45'(a_xc_s1) - 45'(a_ys_s1) + 45'sd32;
		sum_y = 45'(a_xs_s1) + 45'(a_yc_s1) + 45'sd32;
		tot_x = 46'(sum_x >>> ROUND_SHIFT) + 46'($signed({a_px_s1, 8'h00}));
		tot_y = 46'(sum_y >>> ROUND_SHIFT) + 46'($signed({a_py_s1, 8'h00}));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vertex.out_of_range <= a_oor_s1;
			vertex.last         <= a_last_s1;
			if (a_oor_s1) begin
				vertex.vertex_address <= '0;
				vertex.vertex_x       <= '0;
				vertex.vertex_y       <= '0;
				vertex.tex_u          <= '0;
				vertex.tex_v          <= '0;
				vertex.vertex_color   <= '0;
			end else begin
				vertex.vertex_address <= a_addr_s1;
				vertex.tex_u          <= a_u_s1;
				vertex.tex_v          <= a_v_s1;
				vertex.vertex_color   <= a_color_s1;
				if (tot_x > 46'sd2147483647) begin
					vertex.vertex_x <= 32'h7FFFFFFF;
				end else if (tot_x < -46'sd2147483648) begin
					vertex.vertex_x <= 32'h80000000;
				end else begin
					vertex.vertex_x <= tot_x[31:0];
				end
				if (tot_y > 46'sd2147483647) begin
					vertex.vertex_y <= 32'h7FFFFFFF;
				end else if (tot_y < -46'sd2147483648) begin
					vertex.vertex_y <= 32'h80000000;
				end else begin
					vertex.vertex_y <= tot_y[31:0];
				end
			end
		end
	end

endmodule
`default_nettype wire

// ===== src/sprite_quad_vertex_gen.sv =====
// An accepted sprite word passes the setup register, the CORDIC stage registers, the
// sprite register and the product stage into the output register, and its four vertex
// words follow one per cycle while the output port does not stall. A new sprite is taken
// after the last word of the sprite before; capacity-check failures go one per cycle unless stalled.
// Reset: arst_n clears all valid bits and sets the capacity register to 4096.
`default_nettype none
module sprite_quad_vertex_gen
	import sqv_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [12:0] cfg_wdata,
	sqv_sprite_if.sink       sprite,
	sqv_vertex_if.source     vertex
);

	// The vertex capacity, clamped to the buffer size, gates the first vertex of every
	// sprite. The user must write it only while the block is idle; the block does not enforce this.
	logic [12:0] cap_q;
	logic        take;
	logic        item_valid;
	item_t       item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= MAX_VERTICES;
		end else if (cfg_we) begin
			cap_q <= (cfg_wdata < MAX_VERTICES) ? cfg_wdata : MAX_VERTICES;
		end
	end

	// The front end holds the setup stage and the CORDIC stages. The whole front
	// shifts when the corner unit can take the next sprite or when its last stage
	// holds a bubble, so during a stall it keeps shifting until a sprite reaches its last stage.
	sqv_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (take || !item_valid),
		.cap        (cap_q),
		.sprite     (sprite),
		.item_valid (item_valid),
		.item       (item)
	);

	// The corner unit holds one sprite and walks its four corners (one error word for an
	// out-of-range sprite) through a product stage and a rounding stage into the output register.
	sqv_corner u_corner (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.take       (take),
		.vertex     (vertex)
	);

	a_oor_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		vertex.valid && vertex.out_of_range |-> vertex.last)
		else $error("error word without last");

	a_last_corner: assert property (@(posedge clk) disable iff (!arst_n)
		vertex.valid && vertex.last && !vertex.out_of_range
		|-> vertex.vertex_address[1:0] == CORNER_LAST)
		else $error("last vertex is not the bottom-left corner");

	a_oor_fields: assert property (@(posedge clk) disable iff (!arst_n)
		vertex.valid && vertex.out_of_range
		|-> vertex.vertex_address == '0 && vertex.vertex_color == '0)
		else $error("error word carries data");

endmodule
`default_nettype wire
